// ===== rtl/core/obsdm_pkg.sv =====
// Shared types and constants for the one-bit speaker diaphragm model.
// Holds the configuration record, the command word of the internal queue
// and the request and response records of the serial divider.
`timescale 1ns / 1ps

package obsdm_pkg;

   localparam int PosW      = 48;
   localparam int SumW      = 56;
   localparam int FracW     = 16;
   localparam int TimerW    = 24;
   localparam int ElapsedW  = 20;
   localparam int GainW     = 16;
   localparam int ForceW    = 32;
   localparam int StepsW    = 16;
   localparam int DivW      = 8;
   localparam int PeriodW   = 20;
   localparam int SampleW   = 16;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 32;
   localparam int QuotW     = SumW - FracW;
   localparam int CmdDepth  = 2;

   localparam int SampleMaxPos = 32767;
   localparam int SampleMaxNeg = 32768;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SPRING_GAIN      = 3'd0,
      CSR_FRICTION_GAIN    = 3'd1,
      CSR_COIL_FORCE       = 3'd2,
      CSR_FORCE_STEPS      = 3'd3,
      CSR_STEP_DIVIDER     = 3'd4,
      CSR_SAMPLE_PERIOD_NS = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_TOGGLE = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_STEP   = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [ElapsedW-1:0]   elapsed_ns;
   } cmd_type;

   typedef struct packed {
      logic [GainW-1:0]   spring_gain;
      logic [GainW-1:0]   friction_gain;
      logic [ForceW-1:0]  coil_force;
      logic [StepsW-1:0]  force_steps;
      logic [DivW-1:0]    step_divider;
      logic [PeriodW-1:0] sample_period_ns;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [QuotW-1:0]   dividend;
      logic [DivW-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [QuotW-1:0]   quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/obsdm_front.sv =====
// Front end: accepts input words, tracks the physics divider phase and
// classifies each word as a toggle, a plain tick or a physics step.
// Depends on obsdm_pkg.
`timescale 1ns / 1ps

module obsdm_front
   import obsdm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_push,
   input  logic                req_action,
   input  logic [ElapsedW-1:0] req_elapsed_ns,
   input  logic                queue_full,
   output logic                cmd_push,
   output cmd_type             cmd_word
);

   logic [DivW-1:0] div_count_ff;
   logic [DivW-1:0] div_count_in;
   logic [DivW-1:0] div_limit;
   logic [DivW:0]   div_next;

   assign div_limit = (cfg.step_divider == '0) ? DivW'(1) : cfg.step_divider;
   assign div_next  = {1'b0, div_count_ff} + (DivW+1)'(1);
   assign cmd_push  = req_push && !queue_full;

   always_comb begin
      cmd_word.elapsed_ns = req_elapsed_ns;
      if (req_action) begin
         cmd_word.kind = CMD_TOGGLE;
      end else if (div_count_ff == '0) begin
         cmd_word.kind = CMD_STEP;
      end else begin
         cmd_word.kind = CMD_TICK;
      end
   end

   always_comb begin
      div_count_in = div_count_ff;
      if (cmd_push && !req_action) begin
         div_count_in = (div_next >= {1'b0, div_limit}) ? '0 : div_next[DivW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_count_ff <= '0;
      end else begin
         div_count_ff <= div_count_in;
      end
   end

endmodule

// ===== rtl/core/obsdm_cmd_queue.sv =====
// Short command queue between the front end and the physics back end.
// Depends on obsdm_pkg for the command word and the queue depth.
`timescale 1ns / 1ps

module obsdm_cmd_queue
   import obsdm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_word,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   localparam int PtrW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
   localparam int CntW = $clog2(CmdDepth + 1);

   cmd_type         slot_ff [CmdDepth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic            do_push;
   logic            do_pop;

   assign full    = (count_ff == CntW'(CmdDepth));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(CmdDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(CmdDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/obsdm_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the sample average.
// Depends on obsdm_pkg for the divider records and widths.
`timescale 1ns / 1ps

module obsdm_divider
   import obsdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CountW = $clog2(QuotW + 1);

   logic [QuotW-1:0]  quo_ff;
   logic [QuotW-1:0]  quo_in;
   logic [DivW-1:0]   rem_ff;
   logic [DivW-1:0]   rem_in;
   logic [DivW-1:0]   divisor_ff;
   logic [DivW-1:0]   divisor_in;
   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] count_in;
   logic              busy_ff;
   logic              busy_in;
   logic              done_ff;
   logic              done_in;
   logic [DivW:0]     trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[QuotW-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         count_in   = CountW'(QuotW);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[QuotW-2:0], fits};
         rem_in   = fits ? DivW'(trial - {1'b0, divisor_ff}) : trial[DivW-1:0];
         count_in = count_ff - CountW'(1);
         if (count_ff == CountW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/obsdm_back.sv =====
// Back end: carries out queued commands, runs the spring-mass-damper step
// on a shared multiplier and holds the result word for the output side.
// Depends on obsdm_pkg and works with obsdm_divider.
`timescale 1ns / 1ps

module obsdm_back
   import obsdm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               cmd_empty,
   input  cmd_type            cmd_head,
   output logic               cmd_pop,
   output div_req_type        div_req,
   input  div_rsp_type        div_rsp,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [SampleW-1:0] rsp_sample_value
);

   localparam int AccW  = PosW + 3;
   localparam int VsumW = PosW + 4;
   localparam int MulW  = PosW + GainW;

   localparam logic signed [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
   localparam logic signed [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};
   localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
   localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_SNAP = 9'b000000010,
      S_MULP = 9'b000000100,
      S_MULV = 9'b000001000,
      S_VEL  = 9'b000010000,
      S_POS  = 9'b000100000,
      S_SUM  = 9'b001000000,
      S_CHK  = 9'b010000000,
      S_DIV  = 9'b100000000
   } state_type;

   state_type               state_ff, state_in;
   logic signed [PosW-1:0]  pos_ff, pos_in;
   logic signed [PosW-1:0]  vel_ff, vel_in;
   logic signed [PosW-1:0]  sprod_ff, sprod_in;
   logic signed [PosW-1:0]  fprod_ff, fprod_in;
   logic signed [SumW-1:0]  sum_ff, sum_in;
   logic [TimerW-1:0]       timer_ff, timer_in;
   logic [StepsW-1:0]       steps_left_ff, steps_left_in;
   logic [DivW-1:0]         step_total_ff, step_total_in;
   logic                    force_active_ff, force_active_in;
   logic                    force_neg_ff, force_neg_in;
   logic                    next_neg_ff, next_neg_in;
   logic                    sum_neg_ff, sum_neg_in;
   logic                    out_valid_ff, out_valid_in;
   logic [SampleW-1:0]      out_data_ff, out_data_in;
   logic                    emit_wait_ff, emit_wait_in;
   logic [SampleW-1:0]      sample_ff, sample_in;

   logic [TimerW:0]         timer_sum;
   logic [TimerW-1:0]       timer_add;
   logic signed [PosW-1:0]  mul_src;
   logic [GainW-1:0]        mul_gain;
   logic [PosW-1:0]         mul_mag;
   logic [MulW-1:0]         mul_full;
   logic [PosW-1:0]         mul_trunc;
   logic signed [PosW-1:0]  mul_signed;
   logic signed [AccW-1:0]  force_val;
   logic signed [AccW-1:0]  accel;
   logic signed [VsumW-1:0] vsum;
   logic signed [PosW-1:0]  vel_sat;
   logic signed [PosW:0]    psum;
   logic signed [PosW-1:0]  pos_sat;
   logic signed [SumW:0]    ssum;
   logic signed [SumW-1:0]  sum_sat;
   logic [SumW-1:0]         sum_mag;
   logic [SampleW-1:0]      sample_val;
   logic                    pos_tiny;
   logic                    vel_tiny;

   assign timer_sum = {1'b0, timer_ff} + (TimerW+1)'(cmd_head.elapsed_ns);
   assign timer_add = timer_sum[TimerW] ? {TimerW{1'b1}} : timer_sum[TimerW-1:0];

   assign pos_tiny = (pos_ff >= -PosW'(1)) && (pos_ff <= PosW'(2));
   assign vel_tiny = (vel_ff >= -PosW'(1)) && (vel_ff <= PosW'(2));

   assign mul_src    = (state_ff == S_MULP) ? pos_ff : vel_ff;
   assign mul_gain   = (state_ff == S_MULP) ? cfg.spring_gain : cfg.friction_gain;
   assign mul_mag    = mul_src[PosW-1] ? PosW'(-mul_src) : mul_src;
   assign mul_full   = MulW'(mul_mag) * MulW'(mul_gain);
   assign mul_trunc  = mul_full[MulW-1:FracW];
   assign mul_signed = mul_src[PosW-1] ? -$signed(mul_trunc) : $signed(mul_trunc);

   always_comb begin
      force_val = '0;
      if (force_active_ff) begin
         force_val = force_neg_ff ? -$signed(AccW'(cfg.coil_force))
                                  :  $signed(AccW'(cfg.coil_force));
      end
   end

   assign accel = force_val - AccW'(sprod_ff) - AccW'(fprod_ff);
   assign vsum  = VsumW'(vel_ff) + VsumW'(accel);

   always_comb begin
      if (vsum > VsumW'(PosMax)) begin
         vel_sat = PosMax;
      end else if (vsum < VsumW'(PosMin)) begin
         vel_sat = PosMin;
      end else begin
         vel_sat = vsum[PosW-1:0];
      end
   end

   assign psum = (PosW+1)'(pos_ff) + (PosW+1)'(vel_ff);

   always_comb begin
      if (psum > (PosW+1)'(PosMax)) begin
         pos_sat = PosMax;
      end else if (psum < (PosW+1)'(PosMin)) begin
         pos_sat = PosMin;
      end else begin
         pos_sat = psum[PosW-1:0];
      end
   end

   assign ssum = (SumW+1)'(sum_ff) + (SumW+1)'(pos_ff);

   always_comb begin
      if (ssum > (SumW+1)'(SumMax)) begin
         sum_sat = SumMax;
      end else if (ssum < (SumW+1)'(SumMin)) begin
         sum_sat = SumMin;
      end else begin
         sum_sat = ssum[SumW-1:0];
      end
   end

   assign sum_mag = sum_ff[SumW-1] ? SumW'(-sum_ff) : sum_ff;

   always_comb begin
      if (sum_neg_ff) begin
         sample_val = (div_rsp.quotient > QuotW'(SampleMaxNeg))
                    ? SampleW'(SampleMaxNeg)
                    : SampleW'(-div_rsp.quotient[SampleW-1:0]);
      end else begin
         sample_val = (div_rsp.quotient > QuotW'(SampleMaxPos))
                    ? SampleW'(SampleMaxPos)
                    : div_rsp.quotient[SampleW-1:0];
      end
   end

   always_comb begin
      state_in         = state_ff;
      pos_in           = pos_ff;
      vel_in           = vel_ff;
      sprod_in         = sprod_ff;
      fprod_in         = fprod_ff;
      sum_in           = sum_ff;
      timer_in         = timer_ff;
      steps_left_in    = steps_left_ff;
      step_total_in    = step_total_ff;
      force_active_in  = force_active_ff;
      force_neg_in     = force_neg_ff;
      next_neg_in      = next_neg_ff;
      sum_neg_in       = sum_neg_ff;
      out_valid_in     = out_valid_ff;
      out_data_in      = out_data_ff;
      emit_wait_in     = emit_wait_ff;
      sample_in        = sample_ff;
      cmd_pop          = 1'b0;
      div_req          = '0;

      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               case (cmd_head.kind)
                  CMD_TOGGLE: begin
                     steps_left_in   = cfg.force_steps;
                     force_active_in = 1'b1;
                     force_neg_in    = next_neg_ff;
                     next_neg_in     = !next_neg_ff;
                  end
                  CMD_TICK: begin
                     timer_in = timer_add;
                  end
                  CMD_STEP: begin
                     timer_in = timer_add;
                     state_in = S_SNAP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SNAP: begin
            if (pos_tiny) begin
               pos_in = '0;
            end
            if (vel_tiny) begin
               vel_in = '0;
            end
            state_in = S_MULP;
         end
         S_MULP: begin
            sprod_in = mul_signed;
            state_in = S_MULV;
         end
         S_MULV: begin
            fprod_in = mul_signed;
            state_in = S_VEL;
         end
         S_VEL: begin
            vel_in   = vel_sat;
            state_in = S_POS;
         end
         S_POS: begin
            pos_in = pos_sat;
            if (steps_left_ff != '0) begin
               steps_left_in = steps_left_ff - StepsW'(1);
               if (steps_left_ff == StepsW'(1)) begin
                  force_active_in = 1'b0;
               end
            end
            if (step_total_ff != {DivW{1'b1}}) begin
               step_total_in = step_total_ff + DivW'(1);
            end
            state_in = S_SUM;
         end
         S_SUM: begin
            sum_in   = sum_sat;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (timer_ff >= TimerW'(cfg.sample_period_ns)) begin
               div_req.start    = 1'b1;
               div_req.dividend = sum_mag[SumW-1:FracW];
               div_req.divisor  = step_total_ff;
               sum_neg_in       = sum_ff[SumW-1];
               timer_in         = timer_ff - TimerW'(cfg.sample_period_ns);
               sum_in           = '0;
               step_total_in    = '0;
               emit_wait_in     = 1'b0;
               state_in         = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               sample_in    = sample_val;
               emit_wait_in = 1'b1;
            end
            if (emit_wait_ff && (!out_valid_ff || rsp_pop)) begin
               out_valid_in = 1'b1;
               out_data_in  = sample_ff;
               emit_wait_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sprod_ff    <= sprod_in;
      fprod_ff    <= fprod_in;
      sum_neg_ff  <= sum_neg_in;
      out_data_ff <= out_data_in;
      sample_ff   <= sample_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         pos_ff          <= '0;
         vel_ff          <= '0;
         sum_ff          <= '0;
         timer_ff        <= '0;
         steps_left_ff   <= '0;
         step_total_ff   <= '0;
         force_active_ff <= 1'b0;
         force_neg_ff    <= 1'b0;
         next_neg_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         emit_wait_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pos_ff          <= pos_in;
         vel_ff          <= vel_in;
         sum_ff          <= sum_in;
         timer_ff        <= timer_in;
         steps_left_ff   <= steps_left_in;
         step_total_ff   <= step_total_in;
         force_active_ff <= force_active_in;
         force_neg_ff    <= force_neg_in;
         next_neg_ff     <= next_neg_in;
         out_valid_ff    <= out_valid_in;
         emit_wait_ff    <= emit_wait_in;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_sample_value = out_data_ff;

endmodule

// ===== rtl/core/one_bit_speaker_diaphragm_model_unit.sv =====
// Flow: while idle, the back end takes one toggle or plain tick word per cycle
// from the queue. A physics step runs through the snap, spring product,
// friction product, velocity, position, sum and check states; a step that
// emits a sample then waits for the serial divide and a free output register.
// No word is taken during a step; a two-word queue decouples the front end.
// Reset is synchronous: control state clears and settings take their defaults.
`timescale 1ns / 1ps

module one_bit_speaker_diaphragm_model_unit
   import obsdm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic                       req_action,
   input  logic [ElapsedW-1:0]        req_elapsed_ns,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [SampleW-1:0]  rsp_sample_value,
   input  logic                       csr_we,
   input  logic [CsrIdxW-1:0]         csr_index,
   input  logic [CsrDataW-1:0]        csr_wdata
);

   cfg_type            cfg_ff;
   cfg_type            cfg_in;
   logic               queue_full;
   logic               queue_empty;
   logic               cmd_push;
   logic               cmd_pop;
   cmd_type            cmd_word;
   cmd_type            cmd_head;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic [SampleW-1:0] sample_bits;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPRING_GAIN:      cfg_in.spring_gain      = csr_wdata[GainW-1:0];
            CSR_FRICTION_GAIN:    cfg_in.friction_gain    = csr_wdata[GainW-1:0];
            CSR_COIL_FORCE:       cfg_in.coil_force       = csr_wdata[ForceW-1:0];
            CSR_FORCE_STEPS:      cfg_in.force_steps      = csr_wdata[StepsW-1:0];
            CSR_STEP_DIVIDER:     cfg_in.step_divider     = csr_wdata[DivW-1:0];
            CSR_SAMPLE_PERIOD_NS: cfg_in.sample_period_ns = csr_wdata[PeriodW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spring_gain      <= GainW'(655);
         cfg_ff.friction_gain    <= GainW'(3277);
         cfg_ff.coil_force       <= ForceW'(1048576);
         cfg_ff.force_steps      <= StepsW'(8);
         cfg_ff.step_divider     <= DivW'(4);
         cfg_ff.sample_period_ns <= PeriodW'(22676);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = queue_full;

   obsdm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_push       (req_push),
      .req_action     (req_action),
      .req_elapsed_ns (req_elapsed_ns),
      .queue_full     (queue_full),
      .cmd_push       (cmd_push),
      .cmd_word       (cmd_word)
   );

   obsdm_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_word (cmd_word),
      .pop       (cmd_pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head      (cmd_head)
   );

   obsdm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   obsdm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd_empty        (queue_empty),
      .cmd_head         (cmd_head),
      .cmd_pop          (cmd_pop),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_sample_value (sample_bits)
   );

   assign rsp_sample_value = $signed(sample_bits);

endmodule

// ===== tb/diaphragm_sample_monitor.sv =====
// Scoreboard for the one-bit speaker diaphragm model unit: tracks register writes,
// predicts the audio samples from each pushed word and checks every popped word.
// Depends on obsdm_pkg for widths, register indexes and the settings record.
`timescale 1ns / 1ps

module diaphragm_sample_monitor
   import obsdm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic                      req_full,
   input  logic                      req_action,
   input  logic [ElapsedW-1:0]       req_elapsed_ns,
   input  logic                      rsp_empty,
   input  logic                      rsp_pop,
   input  logic signed [SampleW-1:0] rsp_sample_value,
   input  logic                      csr_we,
   input  logic [CsrIdxW-1:0]        csr_index,
   input  logic [CsrDataW-1:0]       csr_wdata,
   output int                        error_count,
   output int                        samples_pending
);

   localparam longint PosMax = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint PosMin = -PosMax - 1;
   localparam longint SumMax = 64'sh007F_FFFF_FFFF_FFFF;
   localparam longint SumMin = -SumMax - 1;
   localparam int unsigned TimerMax = (1 << TimerW) - 1;
   localparam int unsigned StepTotalMax = 255;

   cfg_type settings;
   longint position, velocity, position_sum;
   bit force_on, force_negative, next_negative;
   int unsigned steps_left, divider_phase, timer_ns, steps_summed;
   logic signed [SampleW-1:0] expected_samples[$];
   logic signed [SampleW-1:0] oldest_sample;

   // A gain times a Q31.16 value, truncated toward zero.
   function automatic longint apply_gain(longint value, logic [GainW-1:0] gain);
      bit neg;
      bit [63:0] mag;
      neg = value < 0;
      mag = neg ? -value : value;
      mag = (mag * 64'(gain)) >> FracW;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint clamp(longint value, longint lo, longint hi);
      return (value > hi) ? hi : ((value < lo) ? lo : value);
   endfunction

   task automatic advance_speaker(input logic toggle, input logic [ElapsedW-1:0] elapsed);
      int unsigned div;
      int unsigned period;
      bit run, neg;
      longint force_val, accel, sample;
      bit [63:0] mag;
      period = 32'(settings.sample_period_ns);
      if (toggle) begin
         steps_left = 32'(settings.force_steps);
         force_on = 1'b1;
         force_negative = next_negative;
         next_negative = !next_negative;
      end else begin
         timer_ns = (timer_ns + 32'(elapsed) > TimerMax) ? TimerMax
                                                        : timer_ns + 32'(elapsed);
         div = (settings.step_divider == '0) ? 32'd1 : 32'(settings.step_divider);
         run = (divider_phase == 0);
         divider_phase = (divider_phase + 1 >= div) ? 0 : divider_phase + 1;
         if (run) begin
            if (position >= -1 && position <= 2) position = 0;
            if (velocity >= -1 && velocity <= 2) velocity = 0;
            force_val = longint'({32'd0, settings.coil_force});
            if (!force_on) force_val = 0;
            else if (force_negative) force_val = -force_val;
            accel = -apply_gain(position, settings.spring_gain) + force_val
                    - apply_gain(velocity, settings.friction_gain);
            velocity = clamp(velocity + accel, PosMin, PosMax);
            position = clamp(position + velocity, PosMin, PosMax);
            if (steps_left > 0) begin
               steps_left--;
               if (steps_left == 0) force_on = 1'b0;
            end
            if (steps_summed < StepTotalMax) steps_summed++;
            position_sum = clamp(position_sum + position, SumMin, SumMax);
            if (timer_ns >= period) begin
               neg = position_sum < 0;
               mag = neg ? -position_sum : position_sum;
               mag = mag / (64'(steps_summed) << FracW);
               if (neg) begin
                  sample = (mag > 64'(SampleMaxNeg)) ? -longint'(SampleMaxNeg)
                                                     : -longint'(mag);
               end else begin
                  sample = (mag > 64'(SampleMaxPos)) ? longint'(SampleMaxPos)
                                                     : longint'(mag);
               end
               expected_samples.push_back(sample[SampleW-1:0]);
               timer_ns = timer_ns - period;
               position_sum = 0;
               steps_summed = 0;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         settings.spring_gain = 16'd655;
         settings.friction_gain = 16'd3277;
         settings.coil_force = 32'd1048576;
         settings.force_steps = 16'd8;
         settings.step_divider = 8'd4;
         settings.sample_period_ns = 20'd22676;
         position = 0;
         velocity = 0;
         position_sum = 0;
         force_on = 1'b0;
         force_negative = 1'b0;
         next_negative = 1'b0;
         steps_left = 0;
         divider_phase = 0;
         timer_ns = 0;
         steps_summed = 0;
         expected_samples.delete();
         error_count <= 0;
         samples_pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SPRING_GAIN:      settings.spring_gain = csr_wdata[GainW-1:0];
               CSR_FRICTION_GAIN:    settings.friction_gain = csr_wdata[GainW-1:0];
               CSR_COIL_FORCE:       settings.coil_force = csr_wdata[ForceW-1:0];
               CSR_FORCE_STEPS:      settings.force_steps = csr_wdata[StepsW-1:0];
               CSR_STEP_DIVIDER:     settings.step_divider = csr_wdata[DivW-1:0];
               CSR_SAMPLE_PERIOD_NS: settings.sample_period_ns = csr_wdata[PeriodW-1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) advance_speaker(req_action, req_elapsed_ns);
         if (rsp_pop && !rsp_empty) begin
            if (expected_samples.size() == 0) begin
               $error("sample_value: expected no word, actual %0d", rsp_sample_value);
               error_count <= error_count + 1;
            end else begin
               oldest_sample = expected_samples.pop_front();
               if (rsp_sample_value !== oldest_sample) begin
                  $error("sample_value: expected %0d, actual %0d",
                         oldest_sample, rsp_sample_value);
                  error_count <= error_count + 1;
               end
            end
         end
         samples_pending <= expected_samples.size();
      end
   end

endmodule

// ===== tb/one_bit_speaker_diaphragm_model_unit_test.sv =====
// Top of the testbench for the one-bit speaker diaphragm model unit: drives
// register settings and pushed words with random bursts and pops with stalls.
// Depends on obsdm_pkg, the unit itself and diaphragm_sample_monitor.
`timescale 1ns / 1ps

module one_bit_speaker_diaphragm_model_unit_test;
   import obsdm_pkg::*;

   localparam logic [ElapsedW-1:0] ElapsedMax = '1;
   localparam int SettleCycles = 120;
   localparam int CycleLimit = 1500000;
   localparam int RandomPhases = 6;
   localparam int PhaseWords = 110;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_action = 1'b0;
   logic [ElapsedW-1:0] req_elapsed_ns = '0;
   logic rsp_pop = 1'b0;
   logic csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;
   logic req_full;
   logic rsp_empty;
   logic signed [SampleW-1:0] rsp_sample_value;
   int error_count;
   int samples_pending;
   int cycle_count = 0;
   int burst_left = 1;
   bit push_high = 1'b0;
   int pop_tick = 0;
   int pop_rate = 100;

   always #1 clock = ~clock;

   one_bit_speaker_diaphragm_model_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_action       (req_action),
      .req_elapsed_ns   (req_elapsed_ns),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_sample_value (rsp_sample_value),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   diaphragm_sample_monitor u_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_action       (req_action),
      .req_elapsed_ns   (req_elapsed_ns),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_sample_value (rsp_sample_value),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .samples_pending  (samples_pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // The receiver switches between free flow, coin-flip pops and long stalls.
   always @(posedge clock) begin
      pop_tick <= pop_tick + 1;
      if (pop_tick % 300 == 0) begin
         case ($urandom_range(0, 2))
            0: pop_rate <= 100;
            1: pop_rate <= 50;
            default: pop_rate <= 5;
         endcase
      end
      rsp_pop <= ($urandom_range(0, 99) < pop_rate);
   end

   function automatic logic [ElapsedW-1:0] pick_elapsed();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) return ElapsedW'($urandom_range(0, 4000));
      else if (roll < 9) return ElapsedW'($urandom_range(0, 30000));
      else return ElapsedW'($urandom_range(0, ElapsedMax));
   endfunction

   function automatic logic [GainW-1:0] pick_gain();
      case ($urandom_range(0, 3))
         0: return GainW'($urandom_range(0, 65535));
         1: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
         default: return GainW'($urandom_range(0, 4000));
      endcase
   endfunction

   function automatic cfg_type make_settings(input logic [GainW-1:0] spring,
                                             input logic [GainW-1:0] friction,
                                             input logic [ForceW-1:0] coil,
                                             input logic [StepsW-1:0] steps,
                                             input logic [DivW-1:0] divider,
                                             input logic [PeriodW-1:0] period);
      cfg_type s;
      s.spring_gain = spring;
      s.friction_gain = friction;
      s.coil_force = coil;
      s.force_steps = steps;
      s.step_divider = divider;
      s.sample_period_ns = period;
      return s;
   endfunction

   task automatic push_word(input logic toggle, input logic [ElapsedW-1:0] elapsed);
      req_push <= 1'b1;
      req_action <= toggle;
      req_elapsed_ns <= elapsed;
      push_high = 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         req_push <= 1'b0;
         push_high = 1'b0;
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6))
            @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
      end
   endtask

   task automatic random_words(input int count);
      for (int i = 0; i < count; i++) push_word($urandom_range(0, 4) == 0, pick_elapsed());
   endtask

   // Holds off the sender until every predicted sample has been popped and the
   // back end has had time to finish any step that emits nothing.
   task automatic wait_idle();
      if (push_high) begin
         req_push <= 1'b0;
         push_high = 1'b0;
      end
      do @(posedge clock); while (samples_pending != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic put_reg(input csr_index_type index, input logic [CsrDataW-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_settings(input cfg_type s);
      put_reg(CSR_SPRING_GAIN, CsrDataW'(s.spring_gain));
      put_reg(CSR_FRICTION_GAIN, CsrDataW'(s.friction_gain));
      put_reg(CSR_COIL_FORCE, CsrDataW'(s.coil_force));
      put_reg(CSR_FORCE_STEPS, CsrDataW'(s.force_steps));
      put_reg(CSR_STEP_DIVIDER, CsrDataW'(s.step_divider));
      put_reg(CSR_SAMPLE_PERIOD_NS, CsrDataW'(s.sample_period_ns));
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      push_word(1'b1, '0);
      push_word(1'b0, '0);
      push_word(1'b0, ElapsedMax);
      push_word(1'b0, 20'h55555);
      push_word(1'b0, 20'hAAAAA);
      push_word(1'b1, ElapsedMax);
      for (int i = 0; i < 16; i++) push_word(i % 5 == 4, ElapsedW'($urandom_range(0, 3000)));

      // A zero divider, a zero period and a force that lasts until the next toggle.
      wait_idle();
      load_settings(make_settings(16'd655, 16'd3277, 32'd1048576, 16'd0, 8'd0, 20'd0));
      for (int i = 0; i < 22; i++) push_word(i % 7 == 0, pick_elapsed());

      // A tiny force under heavy damping exercises the snap to zero.
      wait_idle();
      load_settings(make_settings(16'd0, 16'hFFFF, 32'd2, 16'd1, 8'd1, 20'd0));
      for (int i = 0; i < 16; i++) push_word(i % 4 == 0, pick_elapsed());

      // The timer saturates while the divider holds physics off, then drains.
      wait_idle();
      load_settings(make_settings(16'd655, 16'd3277, 32'd1048576, 16'd8, 8'hFF, ElapsedMax));
      for (int i = 0; i < 20; i++) push_word(1'b0, ElapsedMax);
      wait_idle();
      load_settings(make_settings(16'd655, 16'd3277, 32'd1048576, 16'd8, 8'd1, ElapsedMax));
      for (int i = 0; i < 24; i++) push_word(1'b0, '0);

      // A full force with no restoring terms drives position, sum and step count
      // into saturation before a sample is due.
      wait_idle();
      load_settings(make_settings(16'd0, 16'd0, 32'hFFFF_FFFF, 16'd0, 8'd1, ElapsedMax));
      push_word(1'b1, '0);
      for (int i = 0; i < 470; i++) push_word(1'b0, ElapsedW'($urandom_range(0, 1500)));
      push_word(1'b1, ElapsedMax);
      for (int i = 0; i < 34; i++) push_word(1'b0, ElapsedMax);

      wait_idle();
      load_settings(make_settings(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'd1, 20'd1));
      random_words(60);

      for (int p = 0; p < RandomPhases; p++) begin
         wait_idle();
         load_settings(make_settings(
            pick_gain(),
            pick_gain(),
            ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 1 << 22),
            StepsW'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 16)),
            DivW'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(0, 6)),
            PeriodW'(($urandom_range(0, 4) == 0) ? $urandom_range(0, ElapsedMax)
                                                 : $urandom_range(0, 30000))));
         random_words(PhaseWords);
      end

      wait_idle();
      if (error_count == 0 && samples_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
